/* hw/rtl/arx_pkg.sv */
// ----------------------------------------------------------------------------
// arx_pkg
// Shared types and constants of the ARX model step core: sample widths, tap
// counts, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package arx_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // six products of at most 2^62 each, plus sign and margin
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_SH   = 16;
  localparam int RND_W     = ACC_W - FRAC_SH;
  localparam int SUM_W     = RND_W + 1;

  localparam int B_TAPS    = 3;
  localparam int A_TAPS    = 3;
  localparam int ORDER_W   = 2;
  localparam int STEPS     = B_TAPS + A_TAPS;
  localparam int STEP_W    = $clog2(STEPS);

  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B_COEFF_ONE   = 3'd0,
    REG_B_COEFF_TWO   = 3'd1,
    REG_B_COEFF_THREE = 3'd2,
    REG_A_COEFF_ONE   = 3'd3,
    REG_A_COEFF_TWO   = 3'd4,
    REG_A_COEFF_THREE = 3'd5,
    REG_B_ORDER       = 3'd6,
    REG_A_ORDER       = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/arx_model_step_core.sv */
// ----------------------------------------------------------------------------
// arx_model_step_core
// ARX difference-equation plant model: y(k) = sum b_i*u(k-i) - sum a_i*y(k-i)
// + d(k), Q16.16, rounded half up and saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_      | slave     | in_tvalid / in_tready  | tdata: u_sample, disturbance
//  out_     | master    | out_tvalid / out_tready| tdata: y_out; tuser: saturated
//  cfg_     | apb slave | psel, penable, pready  | 8 registers at 4*i
//
//  out_tvalid rises once the sequencer has passed MAC, DRAIN, ROUND and FIN: one
//  signed 32x32 multiplier visits the six taps one per cycle, then drain, rounding
//  and saturation steps. in_tready is high only while the sequencer idles.
//  a result that waits in the output register does not block the next accept,
//  only the next result.
//  reset is synchronous, clears histories and coefficients and sets both orders to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_model_step_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: [31:0] u_sample, [63:32] disturbance
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [2*arx_pkg::SAMPLE_W-1:0]    in_tdata,
  // out_tdata: [31:0] y_out
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [arx_pkg::SAMPLE_W-1:0]           out_tdata,
  // out_tuser: [0] saturated
  output logic [0:0]                             out_tuser,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [arx_pkg::CFG_AW-1:0]        cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int SW = arx_pkg::SAMPLE_W;
  localparam logic signed [arx_pkg::SUM_W-1:0] SUM_MAX =
    arx_pkg::SUM_W'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [arx_pkg::SUM_W-1:0] SUM_MIN = -SUM_MAX - 1;

  arx_pkg::state_t state_r, state_nxt;

  logic signed [arx_pkg::COEF_W-1:0]  b_coef_r [arx_pkg::B_TAPS];
  logic signed [arx_pkg::COEF_W-1:0]  a_coef_r [arx_pkg::A_TAPS];
  logic [arx_pkg::ORDER_W-1:0]        b_order_r, a_order_r;
  logic signed [SW-1:0]               in_hist_r  [arx_pkg::B_TAPS];
  logic signed [SW-1:0]               out_hist_r [arx_pkg::A_TAPS];
  logic                               first_r;

  logic signed [SW-1:0]               u_r, d_r;
  logic [arx_pkg::STEP_W-1:0]         step_r;
  logic signed [arx_pkg::PROD_W-1:0]  prod_r;
  logic                               prod_vld_r, prod_sub_r;
  logic signed [arx_pkg::ACC_W-1:0]   acc_r;
  logic signed [arx_pkg::RND_W-1:0]   rnd_r;

  logic                               out_vld_r, out_sat_r;
  logic signed [SW-1:0]               out_y_r;

  logic                               in_acc, out_acc, cfg_wr;
  arx_pkg::reg_idx_t                  cfg_idx;

  logic signed [SW-1:0]               mul_s;
  logic signed [arx_pkg::COEF_W-1:0]  mul_c;
  logic                               mul_sub;
  logic signed [arx_pkg::PROD_W-1:0]  mul_p;
  logic signed [arx_pkg::ACC_W-1:0]   acc_add;
  logic signed [arx_pkg::ACC_W-1:0]   acc_rnd;
  logic signed [arx_pkg::SUM_W-1:0]   fin_sum;
  logic signed [SW-1:0]               fin_y;
  logic                               fin_sat;
  logic                               fin_load;

  assign in_tready  = (state_r == arx_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_vld_r && out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_y_r;
  assign out_tuser  = out_sat_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = arx_pkg::reg_idx_t'(cfg_paddr[arx_pkg::CFG_AW-1:2]);
  assign fin_load   = (state_r == arx_pkg::ST_FIN) && (!out_vld_r || out_tready);

  // configuration read-back
  always_comb begin
    unique case (cfg_idx)
      arx_pkg::REG_B_COEFF_ONE:   cfg_prdata = b_coef_r[0];
      arx_pkg::REG_B_COEFF_TWO:   cfg_prdata = b_coef_r[1];
      arx_pkg::REG_B_COEFF_THREE: cfg_prdata = b_coef_r[2];
      arx_pkg::REG_A_COEFF_ONE:   cfg_prdata = a_coef_r[0];
      arx_pkg::REG_A_COEFF_TWO:   cfg_prdata = a_coef_r[1];
      arx_pkg::REG_A_COEFF_THREE: cfg_prdata = a_coef_r[2];
      arx_pkg::REG_B_ORDER:       cfg_prdata = {30'd0, b_order_r};
      arx_pkg::REG_A_ORDER:       cfg_prdata = {30'd0, a_order_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < arx_pkg::B_TAPS; i++) b_coef_r[i] <= '0;
      for (int i = 0; i < arx_pkg::A_TAPS; i++) a_coef_r[i] <= '0;
      b_order_r <= arx_pkg::ORDER_W'(3);
      a_order_r <= arx_pkg::ORDER_W'(3);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        arx_pkg::REG_B_COEFF_ONE:   b_coef_r[0] <= cfg_pwdata;
        arx_pkg::REG_B_COEFF_TWO:   b_coef_r[1] <= cfg_pwdata;
        arx_pkg::REG_B_COEFF_THREE: b_coef_r[2] <= cfg_pwdata;
        arx_pkg::REG_A_COEFF_ONE:   a_coef_r[0] <= cfg_pwdata;
        arx_pkg::REG_A_COEFF_TWO:   a_coef_r[1] <= cfg_pwdata;
        arx_pkg::REG_A_COEFF_THREE: a_coef_r[2] <= cfg_pwdata;
        arx_pkg::REG_B_ORDER:       b_order_r   <= cfg_pwdata[arx_pkg::ORDER_W-1:0];
        arx_pkg::REG_A_ORDER:       a_order_r   <= cfg_pwdata[arx_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier: input taps first, then feedback
  always_comb begin
    mul_s   = '0;
    mul_c   = '0;
    mul_sub = 1'b0;
    if (step_r < arx_pkg::STEP_W'(arx_pkg::B_TAPS)) begin
      mul_s = in_hist_r[step_r[1:0]];
      if ({1'b0, step_r} < {1'b0, arx_pkg::STEP_W'(b_order_r)})
        mul_c = b_coef_r[step_r[1:0]];
    end else begin
      mul_s   = out_hist_r[2'(step_r - arx_pkg::STEP_W'(arx_pkg::B_TAPS))];
      mul_sub = 1'b1;
      if (step_r - arx_pkg::STEP_W'(arx_pkg::B_TAPS) < arx_pkg::STEP_W'(a_order_r))
        mul_c = a_coef_r[2'(step_r - arx_pkg::STEP_W'(arx_pkg::B_TAPS))];
    end
  end

  assign mul_p = mul_s * mul_c;

  assign acc_add = prod_sub_r ? acc_r - arx_pkg::ACC_W'(prod_r)
                              : acc_r + arx_pkg::ACC_W'(prod_r);

  // round half up at the Q16.16 point
  assign acc_rnd = acc_r + arx_pkg::ACC_W'(1 << (arx_pkg::FRAC_SH - 1));

  assign fin_sum = arx_pkg::SUM_W'(rnd_r) + arx_pkg::SUM_W'(d_r);

  always_comb begin
    fin_sat = 1'b0;
    fin_y   = fin_sum[SW-1:0];
    if (first_r) begin
      fin_y = '0;
    end else if (fin_sum > SUM_MAX) begin
      fin_y   = {1'b0, {(SW-1){1'b1}}};
      fin_sat = 1'b1;
    end else if (fin_sum < SUM_MIN) begin
      fin_y   = {1'b1, {(SW-1){1'b0}}};
      fin_sat = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arx_pkg::ST_IDLE:  if (in_acc) state_nxt = arx_pkg::ST_MAC;
      arx_pkg::ST_MAC:
        if (step_r == arx_pkg::STEP_W'(arx_pkg::STEPS - 1)) state_nxt = arx_pkg::ST_DRAIN;
      arx_pkg::ST_DRAIN: state_nxt = arx_pkg::ST_ROUND;
      arx_pkg::ST_ROUND: state_nxt = arx_pkg::ST_FIN;
      arx_pkg::ST_FIN:   if (fin_load) state_nxt = arx_pkg::ST_IDLE;
      default:           state_nxt = arx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= arx_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      step_r     <= '0;
    end else begin
      unique case (state_r)
        arx_pkg::ST_IDLE: begin
          prod_vld_r <= 1'b0;
          step_r     <= '0;
        end
        arx_pkg::ST_MAC: begin
          prod_vld_r <= 1'b1;
          step_r     <= step_r + 1'b1;
        end
        default: prod_vld_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      u_r   <= in_tdata[SW-1:0];
      d_r   <= in_tdata[2*SW-1:SW];
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_add;
    end
    if (state_r == arx_pkg::ST_MAC) begin
      prod_r     <= mul_p;
      prod_sub_r <= mul_sub;
    end
    if (state_r == arx_pkg::ST_ROUND) rnd_r <= acc_rnd[arx_pkg::ACC_W-1:arx_pkg::FRAC_SH];
  end

  // histories shift when the result is committed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < arx_pkg::B_TAPS; i++) in_hist_r[i]  <= '0;
      for (int i = 0; i < arx_pkg::A_TAPS; i++) out_hist_r[i] <= '0;
      first_r <= 1'b1;
    end else if (fin_load) begin
      for (int i = arx_pkg::B_TAPS - 1; i > 0; i--) in_hist_r[i]  <= in_hist_r[i-1];
      for (int i = arx_pkg::A_TAPS - 1; i > 0; i--) out_hist_r[i] <= out_hist_r[i-1];
      in_hist_r[0]  <= u_r;
      out_hist_r[0] <= fin_y;
      first_r       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_load) begin
      out_vld_r <= 1'b1;
    end else if (out_acc) begin
      out_vld_r <= 1'b0;
    end
    if (fin_load) begin
      out_y_r   <= fin_y;
      out_sat_r <= fin_sat;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/arx_checker.sv */
// ----------------------------------------------------------------------------
// arx_checker
// Port-level checks for the ARX model step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [arx_pkg::SAMPLE_W-1:0]    out_tdata,
  input wire logic [0:0]                      out_tuser,
  input wire logic                            cfg_pready
);

  // in_tready stays low after a word is taken, while the sequencer works on it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("input taken again too soon");

  // a clipped result sits at one of the range limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata == 32'h7fff_ffff) || (out_tdata == 32'h8000_0000))
    else $error("saturated word not at a range limit");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed under stall");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind arx_model_step_core arx_checker u_arx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

/* bench/tb_arx_model_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arx_model_step_core
// Self-checking bench for the ARX model step core. Words are pushed through
// the input stream and every result is compared with a bit-exact predictor of
// the difference equation. The predictor keeps its own tap settings and
// sample histories. Tap sets are loaded over APB between phases, with the core
// drained, and each phase has its own idle and stall pattern on the streams.
// ----------------------------------------------------------------------------
module tb_arx_model_step_core;

  localparam int STALL_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 20;
  localparam int RAND_PHASES     = 10;
  localparam int WORDS_PER_PHASE = 90;

  localparam logic signed [79:0] ROUND_HALF = 80'sd32768;
  localparam logic signed [79:0] Y_MAX      = 80'sd2147483647;
  localparam logic signed [79:0] Y_MIN      = -80'sd2147483648;

  // first member sits in the high bits, so this matches in_tdata directly
  typedef struct packed {
    logic signed [arx_pkg::SAMPLE_W-1:0] disturb;
    logic signed [arx_pkg::SAMPLE_W-1:0] u;
  } step_word_t;

  typedef struct packed {
    logic                         sat;
    logic [arx_pkg::SAMPLE_W-1:0] y;
  } step_result_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [2*arx_pkg::SAMPLE_W-1:0] in_tdata    = '0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [arx_pkg::SAMPLE_W-1:0]   out_tdata;
  logic [0:0]                     out_tuser;
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [arx_pkg::CFG_AW-1:0]     cfg_paddr   = '0;
  logic [31:0]                    cfg_pwdata  = '0;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  step_word_t   pending_words[$];
  step_result_t y_expected[$];
  int           src_idle_pct  = 0;
  int           snk_stall_pct = 0;
  int           error_count   = 0;
  int           quiet_cycles  = 0;

  // predictor copy of taps and histories
  logic signed [arx_pkg::COEF_W-1:0]   b_tap  [arx_pkg::B_TAPS];
  logic signed [arx_pkg::COEF_W-1:0]   a_tap  [arx_pkg::A_TAPS];
  logic [arx_pkg::ORDER_W-1:0]         b_ord  = 2'd3;
  logic [arx_pkg::ORDER_W-1:0]         a_ord  = 2'd3;
  logic signed [arx_pkg::SAMPLE_W-1:0] u_hist [arx_pkg::B_TAPS];
  logic signed [arx_pkg::SAMPLE_W-1:0] y_hist [arx_pkg::A_TAPS];
  logic                                first_word = 1'b1;

  arx_model_step_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact Q32.32 sum, rounded half up to Q16.16, plus disturbance, clipped
  function automatic step_result_t arx_next_output(input step_word_t w);
    logic signed [79:0] acc;
    logic signed [79:0] s;
    logic signed [79:0] c;
    logic signed [79:0] total;
    step_result_t       r;
    int                 i;
    r.y   = '0;
    r.sat = 1'b0;
    if (!first_word) begin
      acc = '0;
      for (i = 0; i < arx_pkg::B_TAPS; i++) begin
        if (i < b_ord) begin
          s   = u_hist[i];
          c   = b_tap[i];
          acc = acc + s * c;
        end
      end
      for (i = 0; i < arx_pkg::A_TAPS; i++) begin
        if (i < a_ord) begin
          s   = y_hist[i];
          c   = a_tap[i];
          acc = acc - s * c;
        end
      end
      s     = w.disturb;
      total = ((acc + ROUND_HALF) >>> arx_pkg::FRAC_SH) + s;
      if (total > Y_MAX) begin
        r.y   = 32'h7fff_ffff;
        r.sat = 1'b1;
      end else if (total < Y_MIN) begin
        r.y   = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.y = total[arx_pkg::SAMPLE_W-1:0];
      end
    end
    first_word = 1'b0;
    for (i = arx_pkg::B_TAPS - 1; i > 0; i--) u_hist[i] = u_hist[i-1];
    u_hist[0] = w.u;
    for (i = arx_pkg::A_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
    y_hist[0] = r.y;
    return r;
  endfunction

  // mix of full-range, extreme and sign-extended values of span bits
  function automatic logic [31:0] random_value(input int span);
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return r;
      1: begin
        case (r[2:0])
          3'd0:    return 32'h7fff_ffff;
          3'd1:    return 32'h8000_0000;
          3'd2:    return 32'hffff_ffff;
          3'd3:    return 32'h0000_0001;
          default: return '0;
        endcase
      end
      default: return $signed(r << (32 - span)) >>> (32 - span);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic queue_word(input logic [31:0] u, input logic [31:0] d);
    pending_words.push_back('{disturb: d, u: u});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || y_expected.size() != 0);
  endtask

  task automatic write_reg(input arx_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      arx_pkg::REG_B_COEFF_ONE:   b_tap[0] = val;
      arx_pkg::REG_B_COEFF_TWO:   b_tap[1] = val;
      arx_pkg::REG_B_COEFF_THREE: b_tap[2] = val;
      arx_pkg::REG_A_COEFF_ONE:   a_tap[0] = val;
      arx_pkg::REG_A_COEFF_TWO:   a_tap[1] = val;
      arx_pkg::REG_A_COEFF_THREE: a_tap[2] = val;
      arx_pkg::REG_B_ORDER:       b_ord    = val[arx_pkg::ORDER_W-1:0];
      arx_pkg::REG_A_ORDER:       a_ord    = val[arx_pkg::ORDER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_taps(input logic [31:0] b0, input logic [31:0] b1,
                           input logic [31:0] b2, input logic [31:0] a0,
                           input logic [31:0] a1, input logic [31:0] a2,
                           input logic [1:0] bo, input logic [1:0] ao);
    logic [31:0] junk;
    write_reg(arx_pkg::REG_B_COEFF_ONE, b0);
    write_reg(arx_pkg::REG_B_COEFF_TWO, b1);
    write_reg(arx_pkg::REG_B_COEFF_THREE, b2);
    write_reg(arx_pkg::REG_A_COEFF_ONE, a0);
    write_reg(arx_pkg::REG_A_COEFF_TWO, a1);
    write_reg(arx_pkg::REG_A_COEFF_THREE, a2);
    // upper bits of the order registers carry noise
    junk = $urandom();
    junk[1:0] = bo;
    write_reg(arx_pkg::REG_B_ORDER, junk);
    junk = $urandom();
    junk[1:0] = ao;
    write_reg(arx_pkg::REG_A_ORDER, junk);
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) y_expected.push_back(arx_next_output(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_tdata  <= pending_words.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    step_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (y_expected.size() == 0) begin
          report_mismatch($sformatf("result y_out=%h with no word pending", out_tdata));
        end else begin
          want = y_expected.pop_front();
          if (out_tdata !== want.y)
            report_mismatch($sformatf("y_out got %h want %h", out_tdata, want.y));
          if (out_tuser[0] !== want.sat)
            report_mismatch($sformatf("saturated got %b want %b", out_tuser[0], want.sat));
        end
      end
      out_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int          ph;
    int          n;
    logic [31:0] c [6];
    for (n = 0; n < 3; n++) begin
      b_tap[n]  = '0;
      a_tap[n]  = '0;
      u_hist[n] = '0;
      y_hist[n] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset taps are zero, so y follows the disturbance; first word gives zero
    queue_word(32'h7fff_ffff, 32'h1234_5678);
    queue_word(32'h8000_0000, 32'h7fff_ffff);
    queue_word(32'h0000_0000, 32'h8000_0000);
    queue_word(32'h0000_0001, 32'hffff_ffff);
    wait_drained();

    // one lsb on lag one: products land on and just beside rounding halves
    load_taps(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 2'd3, 2'd3);
    queue_word(32'h0000_8000, 32'h0);
    queue_word(32'hffff_8000, 32'h0);
    queue_word(32'h0000_7fff, 32'h0);
    queue_word(32'hffff_7fff, 32'h0);
    queue_word(32'h0001_8000, 32'h0);
    queue_word(32'h0000_0000, 32'h0);
    wait_drained();

    // full equation, driven into both saturation limits
    load_taps(32'h0001_0000, 32'h0000_8000, 32'hffff_c000,
              32'h0000_8000, 32'hffff_c000, 32'h0000_2000, 2'd3, 2'd3);
    queue_word(32'h7fff_ffff, 32'h0);
    queue_word(32'h7fff_ffff, 32'h7fff_ffff);
    queue_word(32'h8000_0000, 32'h8000_0000);
    queue_word(32'h8000_0000, 32'h0);
    queue_word(32'h1234_5678, 32'hffff_0000);
    queue_word(32'h0000_0000, 32'h0);
    queue_word(32'hffff_ffff, 32'h0000_0001);
    queue_word(32'h0000_0000, 32'h0);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 77; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 77; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      for (n = 0; n < 6; n++) begin
        if (ph == 1)      c[n] = 32'h7fff_ffff;
        else if (ph == 2) c[n] = 32'h8000_0000;
        else              c[n] = random_value(17);
      end
      load_taps(c[0], c[1], c[2], c[3], c[4], c[5], 2'(ph % 4), 2'((ph + ph / 4) % 4));
      for (n = 0; n < WORDS_PER_PHASE; n++) queue_word(random_value(20), random_value(20));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && y_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
